### hdl/lzw_dec_pkg.sv
// shared types and constants for the lzw code decoder
`timescale 1ns / 1ps
`default_nettype none

package lzw_dec_pkg;

	// fixed field widths of one beat
	localparam int CODE_W = 12;
	localparam int BYTE_W = 8;

	// codes below this value are literal bytes
	localparam int LIT_CODES = 256;

	// input item kinds
	localparam logic [1:0] KIND_CODE    = 2'd0;
	localparam logic [1:0] KIND_CONT    = 2'd1;
	localparam logic [1:0] KIND_RESTART = 2'd2;

	// error codes on a result
	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_RANGE = 2'd1;
	localparam logic [1:0] ERR_EMPTY = 2'd2;
	localparam logic [1:0] ERR_BUSY  = 2'd3;

	typedef struct packed {
		logic [1:0]        kind;
		logic [CODE_W-1:0] code;
	} in_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              string_end;
		logic              last;
		logic [1:0]        error;
	} out_item_t;

endpackage

`default_nettype wire

### hdl/lzw_dec_ram.sv
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module lzw_dec_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read port, data holds while not reading
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

### hdl/lzw_code_decoder_core.sv
// lzw code decoder top level: dictionary walk, byte stack and output beat
//
// usage:
// - code channel (code_valid, code_stall, code_item): one beat is a kind and a code.
//   kind code decodes a code word, kind continue drains bytes still on the
//   stack, kind restart clears the dictionary and the stream state.
// - byte channel (byte_valid, byte_stall, byte_item): one beat per decoded byte,
//   last marks the final beat of an input beat, string_end the end of a string.
//   error, restart and empty-continue beats carry a zero byte and last set.
// - a code whose string is L bytes long is accepted, its prefix chain is walked
//   (one dictionary read per non-literal code on the chain, read port of the
//   dictionary ram), then the stack is read and the bytes are emitted, at most
//   CHUNK_BYTES bytes per input beat. code_stall is high while an item is at work.
// - for a literal code the first byte beat passes the walk, stack read and
//   output load states; the first code of a stream skips the walk.
// - a stall on the byte channel holds the output register and freezes the
//   drain; the walk itself runs on.
// - reset clears the control state at once; the rams need no clearing, since
//   only entries written since the last restart are ever read.
`timescale 1ns / 1ps
`default_nettype none

module lzw_code_decoder_core
	import lzw_dec_pkg::*;
#(
	parameter int DICT_SIZE   = 4096,
	parameter int CHUNK_BYTES = 64
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      code_valid,
	output logic           code_stall,
	input  wire in_item_t  code_item,
	output logic           byte_valid,
	input  wire logic      byte_stall,
	output out_item_t      byte_item
);

	localparam int AW   = $clog2(DICT_SIZE);
	localparam int NW   = AW + 1;
	localparam int CMPW = (NW > CODE_W) ? NW : CODE_W;
	localparam int CNTW = $clog2(CHUNK_BYTES + 1);
	localparam int DW   = AW + BYTE_W;

	typedef enum logic [4:0] {
		ST_IDLE     = 5'b00001,
		ST_WALK     = 5'b00010,
		ST_DRAIN_RD = 5'b00100,
		ST_DRAIN_LD = 5'b01000,
		ST_RESP     = 5'b10000
	} state_t;

	state_t            state_q;
	logic [NW-1:0]     fill_q;
	logic [NW-1:0]     next_free_q;
	logic [AW-1:0]     prev_code_q;
	logic [BYTE_W-1:0] prev_first_q;
	logic              started_q;
	logic [AW-1:0]     c_q;
	logic [AW-1:0]     code_q;
	logic              rd_pend_q;
	logic [CNTW-1:0]   cnt_q;
	logic              end_pend_q;
	logic              last_pend_q;
	logic [1:0]        resp_err_q;
	logic              byte_valid_q;
	out_item_t         byte_item_q;

	// ram ports
	logic              dict_we;
	logic [AW-1:0]     dict_waddr;
	logic [DW-1:0]     dict_wdata;
	logic              dict_re;
	logic [AW-1:0]     dict_raddr;
	logic [DW-1:0]     dict_rdata;
	logic              stk_we;
	logic [BYTE_W-1:0] stk_wdata;
	logic              stk_re;
	logic [BYTE_W-1:0] stk_rdata;

	// decode helpers
	logic              in_take;
	logic              out_free;
	logic              out_load;
	logic [CMPW-1:0]   code_x;
	logic [AW-1:0]     code_a;
	logic              range_bad;
	logic              is_kwk;
	logic              first_lit_ok;
	logic [AW-1:0]     dict_prefix;
	logic [BYTE_W-1:0] dict_suffix;
	logic              c_lit;
	logic              prefix_lit;
	logic              dict_room;
	logic [NW-1:0]     fill_dec;
	logic [CNTW-1:0]   cnt_inc;
	logic              end_next;
	logic              last_next;

	assign code_stall = (state_q != ST_IDLE);
	assign in_take    = code_valid && !code_stall;
	assign out_free   = !byte_valid_q || !byte_stall;
	assign out_load   = out_free && ((state_q == ST_DRAIN_LD) || (state_q == ST_RESP));
	assign byte_valid = byte_valid_q;
	assign byte_item  = byte_item_q;

	// code checks against the dictionary fill
	assign code_x       = CMPW'(code_item.code);
	assign code_a       = code_x[AW-1:0];
	assign range_bad    = (code_x > CMPW'(next_free_q)) || (code_x >= CMPW'(DICT_SIZE));
	assign is_kwk       = (code_x == CMPW'(next_free_q));
	assign first_lit_ok = (code_x < CMPW'(LIT_CODES));

	assign dict_prefix = dict_rdata[DW-1:BYTE_W];
	assign dict_suffix = dict_rdata[BYTE_W-1:0];
	assign c_lit       = (c_q < AW'(LIT_CODES));
	assign prefix_lit  = (dict_prefix < AW'(LIT_CODES));
	assign dict_room   = (next_free_q < NW'(DICT_SIZE));

	// drain bookkeeping for the next pop
	assign fill_dec  = fill_q - NW'(1);
	assign cnt_inc   = cnt_q + CNTW'(1);
	assign end_next  = (fill_dec == '0);
	assign last_next = end_next || (cnt_inc == CNTW'(CHUNK_BYTES));

	// ram control
	always_comb begin
		dict_we    = 1'b0;
		dict_waddr = next_free_q[AW-1:0];
		dict_wdata = {prev_code_q, c_q[BYTE_W-1:0]};
		dict_re    = 1'b0;
		dict_raddr = c_q;
		stk_we     = 1'b0;
		stk_wdata  = c_q[BYTE_W-1:0];
		stk_re     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_take && code_item.kind == KIND_CODE && fill_q == '0) begin
					if (!started_q) begin
						stk_we    = first_lit_ok;
						stk_wdata = code_x[BYTE_W-1:0];
					end else begin
						stk_we    = !range_bad && is_kwk;
						stk_wdata = prev_first_q;
					end
				end
			end
			ST_WALK: begin
				if (!rd_pend_q) begin
					if (c_lit) begin
						stk_we  = 1'b1;
						dict_we = dict_room;
					end else begin
						dict_re = 1'b1;
					end
				end else begin
					stk_we     = 1'b1;
					stk_wdata  = dict_suffix;
					dict_re    = !prefix_lit;
					dict_raddr = dict_prefix;
				end
			end
			ST_DRAIN_RD: begin
				stk_re = 1'b1;
			end
			ST_DRAIN_LD: begin
				stk_re = out_free && !last_pend_q;
			end
			default: begin
			end
		endcase
	end

	// dictionary: prefix code and suffix byte per entry
	lzw_dec_ram #(
		.WIDTH(DW),
		.DEPTH(DICT_SIZE)
	) u_dict_ram (
		.clk    (clk),
		.wr_en  (dict_we),
		.wr_addr(dict_waddr),
		.wr_data(dict_wdata),
		.rd_en  (dict_re),
		.rd_addr(dict_raddr),
		.rd_data(dict_rdata)
	);

	// byte stack, popped last pushed first
	lzw_dec_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(DICT_SIZE)
	) u_stack_ram (
		.clk    (clk),
		.wr_en  (stk_we),
		.wr_addr(fill_q[AW-1:0]),
		.wr_data(stk_wdata),
		.rd_en  (stk_re),
		.rd_addr(fill_dec[AW-1:0]),
		.rd_data(stk_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			fill_q       <= '0;
			next_free_q  <= NW'(LIT_CODES);
			prev_code_q  <= '0;
			prev_first_q <= '0;
			started_q    <= 1'b0;
			c_q          <= '0;
			code_q       <= '0;
			rd_pend_q    <= 1'b0;
			cnt_q        <= '0;
			end_pend_q   <= 1'b0;
			last_pend_q  <= 1'b0;
			resp_err_q   <= ERR_NONE;
			byte_valid_q <= 1'b0;
			byte_item_q  <= '0;
		end else begin
			// output beat valid: set on a load, cleared once taken
			if (out_load) begin
				byte_valid_q <= 1'b1;
			end else if (!byte_stall) begin
				byte_valid_q <= 1'b0;
			end
			if (stk_we) begin
				fill_q <= fill_q + NW'(1);
			end
			case (state_q)
				ST_IDLE: begin
					cnt_q     <= '0;
					rd_pend_q <= 1'b0;
					if (in_take) begin
						case (code_item.kind)
							KIND_RESTART: begin
								fill_q       <= '0;
								next_free_q  <= NW'(LIT_CODES);
								prev_code_q  <= '0;
								prev_first_q <= '0;
								started_q    <= 1'b0;
								resp_err_q   <= ERR_NONE;
								state_q      <= ST_RESP;
							end
							KIND_CONT: begin
								if (fill_q == '0) begin
									resp_err_q <= ERR_EMPTY;
									state_q    <= ST_RESP;
								end else begin
									state_q <= ST_DRAIN_RD;
								end
							end
							KIND_CODE: begin
								if (fill_q != '0) begin
									resp_err_q <= ERR_BUSY;
									state_q    <= ST_RESP;
								end else if (!started_q) begin
									if (!first_lit_ok) begin
										resp_err_q <= ERR_RANGE;
										state_q    <= ST_RESP;
									end else begin
										prev_code_q  <= code_a;
										prev_first_q <= code_x[BYTE_W-1:0];
										started_q    <= 1'b1;
										state_q      <= ST_DRAIN_RD;
									end
								end else if (range_bad) begin
									resp_err_q <= ERR_RANGE;
									state_q    <= ST_RESP;
								end else begin
									code_q  <= code_a;
									c_q     <= is_kwk ? prev_code_q : code_a;
									state_q <= ST_WALK;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_WALK: begin
					if (!rd_pend_q) begin
						if (c_lit) begin
							// chain ends: new entry while the dictionary has room, then drain
							if (dict_room) begin
								next_free_q <= next_free_q + NW'(1);
							end
							prev_code_q  <= code_q;
							prev_first_q <= c_q[BYTE_W-1:0];
							state_q      <= ST_DRAIN_RD;
						end else begin
							rd_pend_q <= 1'b1;
						end
					end else begin
						c_q       <= dict_prefix;
						rd_pend_q <= !prefix_lit;
					end
				end
				ST_DRAIN_RD: begin
					fill_q      <= fill_dec;
					cnt_q       <= cnt_inc;
					end_pend_q  <= end_next;
					last_pend_q <= last_next;
					state_q     <= ST_DRAIN_LD;
				end
				ST_DRAIN_LD: begin
					if (out_free) begin
						byte_item_q  <= '{data_byte: stk_rdata, string_end: end_pend_q,
							last: last_pend_q, error: ERR_NONE};
						if (last_pend_q) begin
							state_q <= ST_IDLE;
						end else begin
							fill_q      <= fill_dec;
							cnt_q       <= cnt_inc;
							end_pend_q  <= end_next;
							last_pend_q <= last_next;
						end
					end
				end
				ST_RESP: begin
					if (out_free) begin
						byte_item_q  <= '{data_byte: '0, string_end: 1'b0,
							last: 1'b1, error: resp_err_q};
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// a dictionary read is only outstanding during the chain walk
	assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_q |-> state_q == ST_WALK)
		else $error("dictionary read pending outside the walk");

	// the stack never holds more than the dictionary size
	assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= NW'(DICT_SIZE))
		else $error("byte stack overflow");

	// the next free code never drops into the literal range
	assert property (@(posedge clk) disable iff (!arst_n)
		next_free_q >= NW'(LIT_CODES))
		else $error("next free code below the literal range");

	// the end of a string always closes the beats of its item
	assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && byte_item.string_end |-> byte_item.last)
		else $error("string end without last");

endmodule

`default_nettype wire

### verif/tb_lzw_code_decoder_core.sv
// testbench for the lzw code decoder core: predicts every decoded byte beat and checks it
`timescale 1ns / 1ps

module tb_lzw_code_decoder_core;
	import lzw_dec_pkg::*;

	localparam int DICT_SIZE    = 4096;
	localparam int CHUNK_BYTES  = 64;
	localparam int RANDOM_BEATS = 200;
	localparam int QUIET_LIMIT  = 30000;

	// kind with no meaning, the core drops it
	localparam logic [1:0] KIND_SPARE = 2'd3;

	// running model of the decoder with its queue of byte beats still due
	class lzw_string_predictor;
		logic [CODE_W-1:0] link_code [DICT_SIZE];
		logic [BYTE_W-1:0] tail_byte [DICT_SIZE];
		logic [BYTE_W-1:0] byte_stack [DICT_SIZE];
		int                fill;
		logic [CODE_W-1:0] prev_code;
		logic [BYTE_W-1:0] prev_first;
		int                next_free;
		bit                started;
		out_item_t         bytes_due [$];
		int                fault_count;
		int                bytes_matched;
		int                error_results;

		function new();
			clear_stream();
			fault_count   = 0;
			bytes_matched = 0;
			error_results = 0;
		endfunction

		function void clear_stream();
			fill       = 0;
			prev_code  = '0;
			prev_first = '0;
			next_free  = LIT_CODES;
			started    = 1'b0;
		endfunction

		function void add_result(logic [BYTE_W-1:0] b, logic e, logic l, logic [1:0] err);
			out_item_t r;
			r.data_byte  = b;
			r.string_end = e;
			r.last       = l;
			r.error      = err;
			if (err != ERR_NONE)
				error_results++;
			bytes_due = {bytes_due, r};
		endfunction

		// push the string of a code last byte first, hand back its first byte
		function logic [BYTE_W-1:0] walk_chain(logic [CODE_W-1:0] start);
			logic [CODE_W-1:0] c;
			c = start;
			while (c >= LIT_CODES && fill < DICT_SIZE) begin
				byte_stack[fill] = tail_byte[c];
				fill++;
				c = link_code[c];
			end
			if (fill < DICT_SIZE) begin
				byte_stack[fill] = c[BYTE_W-1:0];
				fill++;
			end
			return c[BYTE_W-1:0];
		endfunction

		// pop up to one chunk off the stack
		function void drain_chunk();
			int k;
			k = 0;
			while (fill != 0 && k < CHUNK_BYTES) begin
				fill--;
				add_result(byte_stack[fill], fill == 0, fill == 0 || k == CHUNK_BYTES - 1,
					ERR_NONE);
				k++;
			end
		endfunction

		function void take_beat(in_item_t beat);
			logic [BYTE_W-1:0] first;
			case (beat.kind)
				KIND_RESTART: begin
					clear_stream();
					add_result('0, 1'b0, 1'b1, ERR_NONE);
				end
				KIND_CONT: begin
					if (fill == 0)
						add_result('0, 1'b0, 1'b1, ERR_EMPTY);
					else
						drain_chunk();
				end
				KIND_CODE: begin
					if (fill != 0) begin
						add_result('0, 1'b0, 1'b1, ERR_BUSY);
					end else if (!started) begin
						if (beat.code >= LIT_CODES) begin
							add_result('0, 1'b0, 1'b1, ERR_RANGE);
						end else begin
							byte_stack[0] = beat.code[BYTE_W-1:0];
							fill          = 1;
							prev_code     = beat.code;
							prev_first    = beat.code[BYTE_W-1:0];
							started       = 1'b1;
							drain_chunk();
						end
					end else if (beat.code > next_free || beat.code >= DICT_SIZE) begin
						add_result('0, 1'b0, 1'b1, ERR_RANGE);
					end else begin
						// kwkwk: previous string plus its own first byte
						if (beat.code == next_free) begin
							byte_stack[fill] = prev_first;
							fill++;
							first = walk_chain(prev_code);
						end else begin
							first = walk_chain(beat.code);
						end
						if (next_free < DICT_SIZE) begin
							link_code[next_free] = prev_code;
							tail_byte[next_free] = first;
							next_free++;
						end
						prev_code  = beat.code;
						prev_first = first;
						drain_chunk();
					end
				end
				default: ;
			endcase
		endfunction

		function void check_byte(out_item_t got);
			out_item_t want;
			if (bytes_due.size() == 0) begin
				$display("%0t unexpected byte beat: byte %02h end %0b last %0b err %0d",
					$time, got.data_byte, got.string_end, got.last, got.error);
				fault_count++;
			end else begin
				want = bytes_due.pop_front();
				if (got !== want) begin
					$display({"%0t mismatch: expected byte %02h end %0b last %0b err %0d,",
						" got byte %02h end %0b last %0b err %0d"},
						$time, want.data_byte, want.string_end, want.last, want.error,
						got.data_byte, got.string_end, got.last, got.error);
					fault_count++;
				end else begin
					bytes_matched++;
				end
			end
		endfunction
	endclass

	logic      clk        = 1'b0;
	logic      arst_n     = 1'b0;
	logic      code_valid = 1'b0;
	logic      code_stall;
	in_item_t  code_item  = '0;
	logic      byte_valid;
	logic      byte_stall = 1'b0;
	out_item_t byte_item;

	bit                  calm = 1'b0;
	int                  beats_sent = 0;
	int                  quiet = 0;
	lzw_string_predictor decoder_model = new();

	lzw_code_decoder_core #(
		.DICT_SIZE  (DICT_SIZE),
		.CHUNK_BYTES(CHUNK_BYTES)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.code_valid(code_valid),
		.code_stall(code_stall),
		.code_item (code_item),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_item (byte_item)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// check every accepted byte beat
	always @(posedge clk) begin
		if (arst_n && byte_valid && !byte_stall)
			decoder_model.check_byte(byte_item);
	end

	// watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((code_valid && !code_stall) || (byte_valid && !byte_stall))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("%0t no beat moved for %0d cycles", $time, QUIET_LIMIT);
				$display("tb_lzw_code_decoder_core: errors");
				$finish;
			end
		end
	end

	// receiver stall bursts, switched off in the calm tail
	initial begin
		@(posedge arst_n);
		forever begin
			repeat ($urandom_range(60, 1)) @(posedge clk);
			if (!calm) begin
				byte_stall <= 1'b1;
				repeat ($urandom_range(18, 1)) @(posedge clk);
				byte_stall <= 1'b0;
			end
		end
	end

	// present one code beat, wait for it to be taken, then update the model
	task automatic send_item(input logic [1:0] kind, input logic [CODE_W-1:0] code);
		in_item_t beat;
		beat.kind = kind;
		beat.code = code;
		if (!calm && $urandom_range(3, 0) == 0) begin
			code_valid <= 1'b0;
			repeat ($urandom_range(18, 1)) @(posedge clk);
		end
		code_valid <= 1'b1;
		code_item  <= beat;
		@(posedge clk);
		while (code_stall)
			@(posedge clk);
		decoder_model.take_beat(beat);
		if (kind != KIND_SPARE)
			beats_sent++;
	endtask

	// one beat of a mostly well formed stream, chosen from the model state
	task automatic stream_beat(input bit filling);
		int                roll;
		int                nf;
		logic [CODE_W-1:0] pick;
		roll = $urandom_range(99, 0);
		nf   = decoder_model.next_free;
		if (decoder_model.fill != 0) begin
			// bytes pending: drain them, now and then cut in with a code
			if (!filling && roll < 8)
				send_item(KIND_CODE, CODE_W'($urandom_range(4095, 0)));
			else
				send_item(KIND_CONT, CODE_W'($urandom_range(4095, 0)));
		end else begin
			if (!decoder_model.started) begin
				if (!filling && roll < 10)
					pick = CODE_W'($urandom_range(4095, LIT_CODES));
				else
					pick = CODE_W'($urandom_range(255, 0));
			end else if (filling) begin
				if (roll < 75)
					pick = CODE_W'($urandom_range(255, 0));
				else
					pick = CODE_W'($urandom_range(nf - 1, 0));
			end else if (roll < 30 && nf < DICT_SIZE) begin
				pick = CODE_W'(nf);
			end else if (roll < 50) begin
				pick = CODE_W'(nf - 1);
			end else if (roll < 70) begin
				pick = CODE_W'($urandom_range(255, 0));
			end else if (roll < 93 || nf >= DICT_SIZE - 1) begin
				pick = CODE_W'($urandom_range(nf - 1, 0));
			end else begin
				pick = CODE_W'($urandom_range(4095, nf + 1));
			end
			send_item(KIND_CODE, pick);
		end
	endtask

	initial begin
		int roll;
		int start_count;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners
		send_item(KIND_CONT, 12'h000);
		send_item(KIND_CODE, 12'hFFF);
		send_item(KIND_CODE, 12'h100);
		send_item(KIND_CODE, 12'h000);
		send_item(KIND_CODE, 12'h0FF);
		send_item(KIND_CODE, 12'h102);
		send_item(KIND_CODE, 12'h101);
		send_item(KIND_CODE, 12'h100);
		send_item(KIND_CODE, 12'h102);
		send_item(KIND_SPARE, 12'hABC);
		send_item(KIND_CONT, 12'h555);
		send_item(KIND_CODE, 12'hFFF);
		send_item(KIND_RESTART, 12'hFFF);
		send_item(KIND_CODE, 12'h12C);
		send_item(KIND_CODE, 12'h041);
		send_item(KIND_CODE, 12'h100);
		send_item(KIND_CODE, 12'h101);
		send_item(KIND_CONT, 12'hFFF);
		send_item(KIND_RESTART, 12'h000);

		// random streams with restarts and noise mixed in
		start_count = beats_sent;
		while (beats_sent - start_count < RANDOM_BEATS) begin
			roll = $urandom_range(99, 0);
			if (roll < 8) begin
				send_item(KIND_RESTART, CODE_W'($urandom_range(4095, 0)));
			end else if (roll < 18) begin
				send_item(2'($urandom_range(3, 0)), CODE_W'($urandom_range(4095, 0)));
			end else begin
				repeat ($urandom_range(40, 5))
					stream_beat(1'b0);
			end
		end

		// calm tail: grow a fresh dictionary, then decode against it
		calm = 1'b1;
		send_item(KIND_RESTART, CODE_W'($urandom_range(4095, 0)));
		repeat (30)
			stream_beat(1'b1);
		repeat (60)
			stream_beat(1'b0);
		code_valid <= 1'b0;

		while (decoder_model.bytes_due.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);

		$display("covered %0d code beats, %0d byte beats matched, %0d of them error results",
			beats_sent, decoder_model.bytes_matched, decoder_model.error_results);
		$display("streams mixed kwkwk codes, chunked drains, bad codes and restarts");
		if (decoder_model.fault_count == 0)
			$display("tb_lzw_code_decoder_core: clean");
		else
			$display("tb_lzw_code_decoder_core: errors");
		$finish;
	end

endmodule
